[hdl/i2c_register_transfer_master_macros.svh]
// Assertion macros shared by the I2C register transfer master.
`ifndef I2C_REGISTER_TRANSFER_MASTER_MACROS_SVH
`define I2C_REGISTER_TRANSFER_MASTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define I2C_RTM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("i2c master: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define I2C_RTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("i2c master: next-cycle check failed");

`endif

[hdl/i2c_rtm_pkg.sv]
package i2c_rtm_pkg;

	typedef logic [1:0] opcode_t;
	typedef logic [1:0] kind_t;
	typedef logic [1:0] stage_t;
	typedef logic [4:0] phase_t;

	localparam opcode_t OP_TICK  = 2'd0;
	localparam opcode_t OP_BEGIN = 2'd1;
	localparam opcode_t OP_WBYTE = 2'd2;
	localparam opcode_t OP_NONE  = 2'd3;

	localparam kind_t KIND_WRITE    = 2'd0;
	localparam kind_t KIND_READ     = 2'd1;
	localparam kind_t KIND_PROBE    = 2'd2;
	localparam kind_t KIND_RESERVED = 2'd3;

	localparam stage_t ST_ADDR  = 2'd0;
	localparam stage_t ST_REG   = 2'd1;
	localparam stage_t ST_RADDR = 2'd2;
	localparam stage_t ST_DATA  = 2'd3;

	localparam logic [6:0] DEV_ADDR_RESET = 7'd81;
	localparam logic [3:0] BITS_PER_BYTE  = 4'd8;

endpackage

[hdl/i2c_register_transfer_master.sv]
// I2C register transfer master. Every item (begin, write byte or half-bit tick) is
// accepted into an input register and its result moves on into the output register
// once that register is free or drains, and one item is taken per clock as
// long as results are taken; a stalled result holds the input register, which then
// holds the input channel. Each tick moves the bus one half-bit phase; the block
// drives scl_level/sda_level as open-drain levels (1 released), samples sda_in on
// high phases, raises want_byte when the next write byte must be supplied with a
// write-byte item, and reports done_res with status (1 on a missing acknowledge)
// on the tick that completes STOP. device_address may only be written while idle.
`include "i2c_register_transfer_master_macros.svh"

module i2c_register_transfer_master (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [6:0] device_address,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] opcode,
	input  logic [1:0] transfer_kind,
	input  logic [7:0] register_address,
	input  logic [7:0] byte_count,
	input  logic [7:0] write_byte,
	input  logic       sda_in,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       scl_level,
	output logic       sda_level,
	output logic [7:0] read_byte,
	output logic       read_valid,
	output logic       want_byte,
	output logic       busy_res,
	output logic       done_res,
	output logic       status
);

	localparam i2c_rtm_pkg::phase_t PH_IDLE      = 5'd0;
	localparam i2c_rtm_pkg::phase_t PH_START     = 5'd1;
	localparam i2c_rtm_pkg::phase_t PH_START_LOW = 5'd2;
	localparam i2c_rtm_pkg::phase_t PH_TX_LOW    = 5'd3;
	localparam i2c_rtm_pkg::phase_t PH_TX_HIGH   = 5'd4;
	localparam i2c_rtm_pkg::phase_t PH_ACK_LOW   = 5'd5;
	localparam i2c_rtm_pkg::phase_t PH_ACK_HIGH  = 5'd6;
	localparam i2c_rtm_pkg::phase_t PH_WAIT      = 5'd7;
	localparam i2c_rtm_pkg::phase_t PH_RS_LOW    = 5'd8;
	localparam i2c_rtm_pkg::phase_t PH_RS_HIGH   = 5'd9;
	localparam i2c_rtm_pkg::phase_t PH_RX_LOW    = 5'd10;
	localparam i2c_rtm_pkg::phase_t PH_RX_HIGH   = 5'd11;
	localparam i2c_rtm_pkg::phase_t PH_MACK_LOW  = 5'd12;
	localparam i2c_rtm_pkg::phase_t PH_MACK_HIGH = 5'd13;
	localparam i2c_rtm_pkg::phase_t PH_STOP_LOW  = 5'd14;
	localparam i2c_rtm_pkg::phase_t PH_STOP_HIGH = 5'd15;
	localparam i2c_rtm_pkg::phase_t PH_STOP_END  = 5'd16;

	// Configuration.
	logic [6:0] dev_addr_q;

	// Input register.
	logic                   valid_s1;
	i2c_rtm_pkg::opcode_t   opcode_s1;
	i2c_rtm_pkg::kind_t     kind_s1;
	logic [7:0]             reg_addr_s1;
	logic [7:0]             count_s1;
	logic [7:0]             wbyte_s1;
	logic                   sda_s1;

	// Controller state.
	i2c_rtm_pkg::phase_t    phase_q, phase_d;
	logic [3:0]             bit_cnt_q, bit_cnt_d;
	logic [7:0]             shift_q, shift_d;
	logic [7:0]             bytes_left_q, bytes_left_d;
	i2c_rtm_pkg::kind_t     kind_q, kind_d;
	logic [7:0]             reg_q, reg_d;
	logic                   ack_failed_q, ack_failed_d;
	logic                   scl_q, scl_d;
	logic                   sda_q, sda_d;
	i2c_rtm_pkg::stage_t    stage_q, stage_d;

	// Result register.
	logic                   out_valid_q;
	logic [7:0]             read_byte_q;
	logic                   read_valid_q;
	logic                   want_byte_q;
	logic                   busy_q;
	logic                   done_q;
	logic                   status_q;

	logic       advance;
	logic       load_s1;
	logic       rvalid_d;
	logic [7:0] rbyte_d;
	logic       done_d;
	logic       status_d;
	logic [7:0] rx_shift;
	logic [3:0] bit_cnt_inc;

	assign cfg_ready = 1'b1;

	// The input register moves on whenever the result register is free or drains.
	assign advance  = !out_valid_q || !out_stall;
	// An empty input register takes an item even while the result is stalled.
	assign load_s1  = !valid_s1 || advance;
	assign in_stall = valid_s1 && !advance;

	assign rx_shift    = {shift_q[6:0], sda_s1};
	assign bit_cnt_inc = bit_cnt_q + 4'd1;

	always_comb begin
		phase_d      = phase_q;
		bit_cnt_d    = bit_cnt_q;
		shift_d      = shift_q;
		bytes_left_d = bytes_left_q;
		kind_d       = kind_q;
		reg_d        = reg_q;
		ack_failed_d = ack_failed_q;
		scl_d        = scl_q;
		sda_d        = sda_q;
		stage_d      = stage_q;
		rvalid_d     = 1'b0;
		rbyte_d      = 8'd0;
		done_d       = 1'b0;
		status_d     = 1'b0;

		unique case (opcode_s1)
			i2c_rtm_pkg::OP_BEGIN: begin
				if (phase_q == PH_IDLE && kind_s1 != i2c_rtm_pkg::KIND_RESERVED) begin
					kind_d       = kind_s1;
					reg_d        = reg_addr_s1;
					bytes_left_d = count_s1;
					if (kind_s1 == i2c_rtm_pkg::KIND_READ && count_s1 == 8'd0) begin
						bytes_left_d = 8'd1;
					end
					ack_failed_d = 1'b0;
					stage_d      = i2c_rtm_pkg::ST_ADDR;
					shift_d      = {dev_addr_q, 1'b0};
					bit_cnt_d    = 4'd0;
					phase_d      = PH_START;
				end
			end
			i2c_rtm_pkg::OP_WBYTE: begin
				if (phase_q == PH_WAIT) begin
					shift_d   = wbyte_s1;
					bit_cnt_d = 4'd0;
					phase_d   = PH_TX_LOW;
				end
			end
			i2c_rtm_pkg::OP_TICK: begin
				unique case (phase_q)
					PH_START: begin
						scl_d   = 1'b1;
						sda_d   = 1'b0;
						phase_d = PH_START_LOW;
					end
					PH_START_LOW: begin
						scl_d     = 1'b0;
						bit_cnt_d = 4'd0;
						phase_d   = PH_TX_LOW;
					end
					PH_TX_LOW: begin
						scl_d   = 1'b0;
						sda_d   = shift_q[7];
						phase_d = PH_TX_HIGH;
					end
					PH_TX_HIGH: begin
						scl_d     = 1'b1;
						shift_d   = {shift_q[6:0], 1'b0};
						bit_cnt_d = bit_cnt_inc;
						phase_d   = (bit_cnt_inc >= i2c_rtm_pkg::BITS_PER_BYTE) ?
							PH_ACK_LOW : PH_TX_LOW;
					end
					PH_ACK_LOW: begin
						scl_d   = 1'b0;
						sda_d   = 1'b1;
						phase_d = PH_ACK_HIGH;
					end
					PH_ACK_HIGH: begin
						scl_d = 1'b1;
						if (sda_s1) begin
							ack_failed_d = 1'b1;
							phase_d      = PH_STOP_LOW;
						end else begin
							case (stage_q)
								i2c_rtm_pkg::ST_ADDR: begin
									if (kind_q == i2c_rtm_pkg::KIND_PROBE) begin
										phase_d = PH_STOP_LOW;
									end else begin
										stage_d   = i2c_rtm_pkg::ST_REG;
										shift_d   = reg_q;
										bit_cnt_d = 4'd0;
										phase_d   = PH_TX_LOW;
									end
								end
								i2c_rtm_pkg::ST_REG: begin
									if (kind_q == i2c_rtm_pkg::KIND_READ) begin
										phase_d = PH_RS_LOW;
									end else begin
										stage_d = i2c_rtm_pkg::ST_DATA;
										phase_d = (bytes_left_q == 8'd0) ? PH_STOP_LOW : PH_WAIT;
									end
								end
								i2c_rtm_pkg::ST_RADDR: begin
									shift_d   = 8'd0;
									bit_cnt_d = 4'd0;
									phase_d   = PH_RX_LOW;
								end
								default: begin
									// A data byte was acknowledged.
									if (bytes_left_q > 8'd1) begin
										bytes_left_d = bytes_left_q - 8'd1;
										phase_d      = PH_WAIT;
									end else begin
										bytes_left_d = 8'd0;
										phase_d      = PH_STOP_LOW;
									end
								end
							endcase
						end
					end
					PH_RS_LOW: begin
						scl_d   = 1'b0;
						sda_d   = 1'b1;
						phase_d = PH_RS_HIGH;
					end
					PH_RS_HIGH: begin
						scl_d   = 1'b1;
						sda_d   = 1'b1;
						stage_d = i2c_rtm_pkg::ST_RADDR;
						shift_d = {dev_addr_q, 1'b1};
						phase_d = PH_START;
					end
					PH_RX_LOW: begin
						scl_d   = 1'b0;
						sda_d   = 1'b1;
						phase_d = PH_RX_HIGH;
					end
					PH_RX_HIGH: begin
						scl_d     = 1'b1;
						shift_d   = rx_shift;
						bit_cnt_d = bit_cnt_inc;
						if (bit_cnt_inc >= i2c_rtm_pkg::BITS_PER_BYTE) begin
							rvalid_d = 1'b1;
							rbyte_d  = rx_shift;
							if (bytes_left_q != 8'd0) begin
								bytes_left_d = bytes_left_q - 8'd1;
							end
							phase_d = PH_MACK_LOW;
						end else begin
							phase_d = PH_RX_LOW;
						end
					end
					PH_MACK_LOW: begin
						// Acknowledge while more bytes follow, NACK after the last one.
						scl_d   = 1'b0;
						sda_d   = (bytes_left_q == 8'd0);
						phase_d = PH_MACK_HIGH;
					end
					PH_MACK_HIGH: begin
						scl_d = 1'b1;
						if (bytes_left_q != 8'd0) begin
							shift_d   = 8'd0;
							bit_cnt_d = 4'd0;
							phase_d   = PH_RX_LOW;
						end else begin
							phase_d = PH_STOP_LOW;
						end
					end
					PH_STOP_LOW: begin
						scl_d   = 1'b0;
						sda_d   = 1'b0;
						phase_d = PH_STOP_HIGH;
					end
					PH_STOP_HIGH: begin
						scl_d   = 1'b1;
						sda_d   = 1'b0;
						phase_d = PH_STOP_END;
					end
					PH_STOP_END: begin
						sda_d    = 1'b1;
						done_d   = 1'b1;
						status_d = ack_failed_q;
						phase_d  = PH_IDLE;
					end
					default: begin
						// Idle, or waiting for a write byte: a tick changes nothing.
					end
				endcase
			end
			default: begin
				// The unused opcode changes nothing.
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= i2c_rtm_pkg::DEV_ADDR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			dev_addr_q <= device_address;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			opcode_s1   <= opcode;
			kind_s1     <= transfer_kind;
			reg_addr_s1 <= register_address;
			count_s1    <= byte_count;
			wbyte_s1    <= write_byte;
			sda_s1      <= sda_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			bit_cnt_q    <= 4'd0;
			shift_q      <= 8'd0;
			bytes_left_q <= 8'd0;
			kind_q       <= i2c_rtm_pkg::KIND_WRITE;
			reg_q        <= 8'd0;
			ack_failed_q <= 1'b0;
			scl_q        <= 1'b1;
			sda_q        <= 1'b1;
			stage_q      <= i2c_rtm_pkg::ST_ADDR;
		end else if (advance && valid_s1) begin
			phase_q      <= phase_d;
			bit_cnt_q    <= bit_cnt_d;
			shift_q      <= shift_d;
			bytes_left_q <= bytes_left_d;
			kind_q       <= kind_d;
			reg_q        <= reg_d;
			ack_failed_q <= ack_failed_d;
			scl_q        <= scl_d;
			sda_q        <= sda_d;
			stage_q      <= stage_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			read_byte_q  <= rbyte_d;
			read_valid_q <= rvalid_d;
			want_byte_q  <= (phase_d == PH_WAIT);
			busy_q       <= (phase_d != PH_IDLE);
			done_q       <= done_d;
			status_q     <= status_d;
		end
	end

	// Line levels always reflect the controller state, which only moves with a result.
	assign out_valid  = out_valid_q;
	assign scl_level  = scl_q;
	assign sda_level  = sda_q;
	assign read_byte  = read_byte_q;
	assign read_valid = read_valid_q;
	assign want_byte  = want_byte_q;
	assign busy_res   = busy_q;
	assign done_res   = done_q;
	assign status     = status_q;

	`I2C_RTM_ASSERT_NOW(a_done_idle, clk, arst_n, out_valid_q && done_q, !busy_q && sda_q && scl_q)
	`I2C_RTM_ASSERT_NOW(a_status_done, clk, arst_n, out_valid_q && status_q, done_q)
	`I2C_RTM_ASSERT_NOW(a_read_busy, clk, arst_n, out_valid_q && read_valid_q, busy_q && scl_q)
	`I2C_RTM_ASSERT_NOW(a_want_busy, clk, arst_n, out_valid_q && want_byte_q, busy_q && scl_q)
	`I2C_RTM_ASSERT_NEXT(a_stall_hold, clk, arst_n, valid_s1 && !advance, valid_s1 && $stable(opcode_s1))

endmodule
